// ===== hw/rtl/chs_pkg.sv =====
package chs_pkg;

	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int HW         = 9;   // heading width
	localparam int TOL_W      = 9;
	localparam int OUT_W      = 16;
	localparam int ANGLE_FRAC = 16;
	localparam int HALF_TURN  = 180;
	localparam int TOL_RESET  = 15;
	localparam int TAB_LEN    = 24;
	localparam int TAB_W      = 22;
	localparam int ZW         = 27;  // angle accumulator, degrees in q16
	localparam int DW         = ZW - ANGLE_FRAC;

	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_CAL     = 2'd1;
	localparam logic [1:0] MODE_CAPTURE = 2'd2;
	localparam logic [1:0] MODE_STEER   = 2'd3;

	localparam logic signed [ZW-1:0] Z_HALF    = ZW'(HALF_TURN * (1 << ANGLE_FRAC));
	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'((HALF_TURN / 2) * (1 << ANGLE_FRAC));
	localparam logic signed [ZW-1:0] Z_FRAC    = ZW'((1 << ANGLE_FRAC) - 1);
	localparam logic signed [DW-1:0] DEG_MAX   = DW'(HALF_TURN);
	localparam logic signed [DW-1:0] DEG_MIN   = -DW'(HALF_TURN);

	// atan(2^-i) in degrees, q16
	localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379, 22'd117304, 22'd58666, 22'd29335,
		22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115,
		22'd57, 22'd29, 22'd14, 22'd7,
		22'd4, 22'd2, 22'd1, 22'd0
	};

	function automatic logic [TAB_W-1:0] atan_at(input logic [4:0] idx);
		logic [TAB_W-1:0] r;
		r = '0;
		if (idx < 5'(TAB_LEN)) begin
			r = ATAN_TAB[idx];
		end
		return r;
	endfunction

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_CENTER,
		S_START,
		S_WAIT,
		S_OUT
	} chs_state_t;

	typedef enum logic {
		C_IDLE,
		C_ITER
	} cordic_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_sts_t;

endpackage

// ===== hw/rtl/chs_cordic.sv =====
module chs_cordic
	import chs_pkg::*;
#(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS+1:0] cx,
	input  logic signed [SAMPLE_BITS+1:0] cy,
	output logic signed [ZW-1:0]          z,
	output cordic_sts_t                   sts
);

	localparam int CW    = SAMPLE_BITS + 2;
	localparam int W     = CW + ANGLE_FRAC + 2;  // headroom for cordic gain
	localparam int STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int IW    = $clog2(STEPS + 1);

	cordic_state_t state_q, state_d;
	logic signed [W-1:0]  x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0]        i_q;

	logic signed [W-1:0]  xl, yl, sx, sy;
	logic signed [ZW-1:0] ang;
	logic                 finish;

	assign xl     = {{2{cx[CW-1]}}, cx, {ANGLE_FRAC{1'b0}}};
	assign yl     = {{2{cy[CW-1]}}, cy, {ANGLE_FRAC{1'b0}}};
	assign sx     = x_q >>> i_q;
	assign sy     = y_q >>> i_q;
	assign ang    = $signed(ZW'(atan_at(5'(i_q))));
	assign finish = (y_q == '0) || (i_q == IW'(STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sts.busy = 1'b0;
		sts.done = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					state_d = C_ITER;
				end
			end
			C_ITER: begin
				sts.busy = 1'b1;
				if (finish) begin
					sts.done = 1'b1;
					state_d  = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			i_q <= '0;
			// axis cases are exact: park y at zero so no step runs
			priority if (cx == '0 && cy == '0) begin
				x_q <= xl;
				y_q <= '0;
				z_q <= '0;
			end else if (cy == '0) begin
				x_q <= xl;
				y_q <= '0;
				z_q <= cx[CW-1] ? Z_HALF : '0;
			end else if (cx == '0) begin
				x_q <= xl;
				y_q <= '0;
				z_q <= cy[CW-1] ? -Z_QUARTER : Z_QUARTER;
			end else if (cx[CW-1]) begin
				x_q <= -xl;
				y_q <= -yl;
				z_q <= cy[CW-1] ? -Z_HALF : Z_HALF;
			end else begin
				x_q <= xl;
				y_q <= yl;
				z_q <= '0;
			end
		end else if (state_q == C_ITER && !finish) begin
			i_q <= i_q + IW'(1);
			if (!y_q[W-1]) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - ang;
			end
		end
	end

	assign z = z_q;

endmodule

// ===== hw/rtl/compass_heading_steer.sv =====
// compass heading and steer decision
// input stream: s_tdata = {mag_y, mag_x} (two signed samples, mag_x low), s_tuser = mode
//   (0 start calibration, 1 calibration sample, 2 capture target, 3 steer)
// output stream: m_tdata = {zeros, drive_forward, heading_deg} with heading in
//   signed whole degrees, one result transaction per input transaction
// cfg_we / cfg_wdata write the heading tolerance in degrees (reset 15)
// an accepted sample goes through range update, centering, then a shared
// shift-add cordic unit doing one rotation per cycle, stopping when y reaches
// zero or at its step limit; the result then waits for the output register,
// and the next sample is taken
// the cycle after the result is loaded
// s_tready is high only while the sequencer is idle; one finished result may
// wait in the output register while the next sample is accepted
// if the receiver stalls, the next result waits inside until the output
// register empties
// reset clears the ranges and target to zero, the tolerance to 15 and
// drops m_tvalid
module compass_heading_steer
	import chs_pkg::*;
#(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // mag_x, mag_y
	input  logic [1:0]                             s_tuser,   // mode
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [OUT_W-1:0]                       m_tdata,   // heading_deg, drive_forward
	input  logic                                   cfg_we,
	input  logic [TOL_W-1:0]                       cfg_wdata
);

	localparam int SB = SAMPLE_BITS;
	localparam int CW = SB + 2;

	chs_state_t state_q, state_d;

	logic [1:0]              mode_q;
	logic signed [SB-1:0]    mx_q, my_q;
	logic signed [SB-1:0]    x_max_q, x_min_q, y_max_q, y_min_q;
	logic signed [HW-1:0]    target_q;
	logic [TOL_W-1:0]        tol_q;
	logic signed [CW-1:0]    cx_q, cy_q;
	logic                    m_tvalid_q;
	logic signed [HW-1:0]    heading_q;
	logic                    fwd_q;

	logic                    start;
	logic                    load;
	logic signed [ZW-1:0]    z;
	cordic_sts_t             sts;

	logic signed [ZW-1:0]    z_bias;
	logic signed [DW-1:0]    deg_t;
	logic signed [HW-1:0]    heading;
	logic signed [HW:0]      diff;
	logic [HW:0]             diff_abs;
	logic                    fwd;

	chs_cordic #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cx    (cx_q),
		.cy    (cy_q),
		.z     (z),
		.sts   (sts)
	);

	// truncate toward zero, then clamp to a half turn
	assign z_bias = z + (z[ZW-1] ? Z_FRAC : '0);
	always_comb begin
		deg_t = z_bias[ZW-1:ANGLE_FRAC];
		if (deg_t > DEG_MAX) begin
			deg_t = DEG_MAX;
		end else if (deg_t < DEG_MIN) begin
			deg_t = DEG_MIN;
		end
	end
	assign heading  = deg_t[HW-1:0];
	assign diff     = {heading[HW-1], heading} - {target_q[HW-1], target_q};
	assign diff_abs = diff[HW] ? (HW+1)'(-diff) : diff;
	assign fwd      = (mode_q == MODE_STEER) && (diff_abs < {1'b0, tol_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		start    = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_RANGE;
				end
			end
			S_RANGE:  state_d = S_CENTER;
			S_CENTER: state_d = S_START;
			S_START: begin
				start   = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (sts.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q <= s_tuser;
			mx_q   <= s_tdata[SB-1:0];
			my_q   <= s_tdata[2*SB-1:SB];
		end
		if (state_q == S_CENTER) begin
			cx_q <= {mx_q[SB-1], mx_q, 1'b0}
				- ({{2{x_max_q[SB-1]}}, x_max_q} + {{2{x_min_q[SB-1]}}, x_min_q});
			cy_q <= {my_q[SB-1], my_q, 1'b0}
				- ({{2{y_max_q[SB-1]}}, y_max_q} + {{2{y_min_q[SB-1]}}, y_min_q});
		end
		if (load) begin
			heading_q <= heading;
			fwd_q     <= fwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_max_q    <= '0;
			x_min_q    <= '0;
			y_max_q    <= '0;
			y_min_q    <= '0;
			target_q   <= '0;
			tol_q      <= TOL_W'(TOL_RESET);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (state_q == S_RANGE) begin
				if (mode_q == MODE_START) begin
					x_max_q <= mx_q;
					x_min_q <= mx_q;
					y_max_q <= my_q;
					y_min_q <= my_q;
				end else if (mode_q == MODE_CAL) begin
					if (mx_q > x_max_q) x_max_q <= mx_q;
					if (mx_q < x_min_q) x_min_q <= mx_q;
					if (my_q > y_max_q) y_max_q <= my_q;
					if (my_q < y_min_q) y_min_q <= my_q;
				end
			end
			if (load && mode_q == MODE_CAPTURE) begin
				target_q <= heading;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W-HW-1){1'b0}}, fwd_q, heading_q};

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample accepted while the sequencer was busy");

	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == S_WAIT)
		else $error("cordic finished outside the wait state");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !sts.busy)
		else $error("cordic started while busy");

	a_fwd_only_steer: assert property (@(posedge clk) disable iff (!arst_n)
		load && mode_q != MODE_STEER |=> !m_tdata[HW])
		else $error("drive_forward set outside steer mode");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[HW-1:0]) <= $signed(DEG_MAX[HW-1:0]))
			&& ($signed(m_tdata[HW-1:0]) >= $signed(DEG_MIN[HW-1:0])))
		else $error("heading outside a half turn");
`endif

endmodule

// ===== bench/compass_heading_steer_test.sv =====
`timescale 1ns / 1ps

typedef struct {
	logic signed [chs_pkg::HW-1:0] heading;
	logic                          forward;
} steer_result_t;

class heading_tracker;
	logic signed [15:0]            x_max, x_min, y_max, y_min;
	logic signed [chs_pkg::HW-1:0] target;
	logic [chs_pkg::TOL_W-1:0]     tolerance;
	steer_result_t                 expected_steer[$];
	int                            mismatches;

	// atan(2^-i) in degrees, 16 fraction bits
	longint atan_q16[24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	function new();
		x_max = '0;
		x_min = '0;
		y_max = '0;
		y_min = '0;
		target = '0;
		tolerance = 9'(chs_pkg::TOL_RESET);
		mismatches = 0;
	endfunction

	function int pending();
		return expected_steer.size();
	endfunction

	// vectoring cordic, angle in degrees q16, truncated toward zero
	function int heading_of(longint cx, longint cy);
		longint x, y, z, nx, ny, deg;
		x = cx * 65536;
		y = cy * 65536;
		z = 0;
		if (cx == 0 && cy == 0)
			return 0;
		if (cy == 0)
			return (cx > 0) ? 0 : 180;
		if (cx == 0)
			return (cy > 0) ? 90 : -90;
		if (x < 0) begin
			z = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < chs_pkg::CORDIC_STEPS_DEF && y != 0; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_q16[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_q16[i];
			end
			x = nx;
			y = ny;
		end
		deg = z / 65536;
		if (deg > 180)
			deg = 180;
		if (deg < -180)
			deg = -180;
		return int'(deg);
	endfunction

	function void note_sample(logic [1:0] mode, logic signed [15:0] mx, logic signed [15:0] my);
		steer_result_t r;
		int            h;
		int            err;
		if (mode == chs_pkg::MODE_START) begin
			x_max = mx;
			x_min = mx;
			y_max = my;
			y_min = my;
		end else if (mode == chs_pkg::MODE_CAL) begin
			if (mx > x_max) x_max = mx;
			if (mx < x_min) x_min = mx;
			if (my > y_max) y_max = my;
			if (my < y_min) y_min = my;
		end
		// centers kept at double scale
		h = heading_of(2 * longint'(mx) - (longint'(x_max) + longint'(x_min)),
			2 * longint'(my) - (longint'(y_max) + longint'(y_min)));
		r.heading = h[chs_pkg::HW-1:0];
		r.forward = 1'b0;
		if (mode == chs_pkg::MODE_CAPTURE) begin
			target = h[chs_pkg::HW-1:0];
		end else if (mode == chs_pkg::MODE_STEER) begin
			// plain difference, no wrap at the half turn
			err = h - int'(target);
			if (err < 0)
				err = -err;
			r.forward = (err < int'(tolerance));
		end
		expected_steer.push_back(r);
	endfunction

	task report_mismatch(string what);
		$display("ERROR @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	task check_steer(logic [chs_pkg::OUT_W-1:0] data);
		steer_result_t r;
		if (expected_steer.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing outstanding", data));
			return;
		end
		r = expected_steer.pop_front();
		if (data[chs_pkg::HW-1:0] !== r.heading)
			report_mismatch($sformatf("heading %0d, expected %0d",
				$signed(data[chs_pkg::HW-1:0]), r.heading));
		if (data[chs_pkg::HW] !== r.forward)
			report_mismatch($sformatf("drive_forward %b, expected %b",
				data[chs_pkg::HW], r.forward));
		if (data[chs_pkg::OUT_W-1:chs_pkg::HW+1] !== '0)
			report_mismatch($sformatf("padding bits set in %h", data));
	endtask
endclass

module compass_heading_steer_test;
	import chs_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [31:0]            s_tdata;   // mag_x, mag_y
	logic [1:0]             s_tuser;   // mode
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_W-1:0]       m_tdata;   // heading_deg, drive_forward
	logic                   cfg_we;
	logic [TOL_W-1:0]       cfg_wdata;

	heading_tracker board = new();
	bit                     calm;
	logic                   rx_hold;
	int                     accepted;
	int                     cycles;

	compass_heading_steer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_sample(input logic [1:0] mode, input logic signed [15:0] mx,
		input logic signed [15:0] my);
		while (!calm && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {my, mx};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		board.note_sample(mode, mx, my);
		accepted++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		board.tolerance = value;
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] around(input int c, input int spread);
		int v;
		v = c + int'($urandom_range(2 * spread)) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// one calibrate / capture / steer run with random content, or noise
	task automatic run_episode(output int n);
		int                 cx, cy, spread, kind;
		logic signed [15:0] tx, ty;
		n = 0;
		kind = $urandom_range(99);
		if (kind < 15) begin
			repeat ($urandom_range(8, 1)) begin
				send_sample(2'($urandom), 16'($urandom), 16'($urandom));
				n++;
			end
			return;
		end
		case ($urandom_range(3))
			0: spread = 20;
			1: spread = 600;
			2: spread = 6000;
			default: spread = 32767;
		endcase
		cx = int'($urandom_range(32000)) - 16000;
		cy = int'($urandom_range(32000)) - 16000;
		// some runs skip the start to keep stale ranges
		if (kind >= 25) begin
			send_sample(MODE_START, around(cx, spread), around(cy, spread));
			n++;
		end
		repeat ($urandom_range(10, 2)) begin
			send_sample(MODE_CAL, around(cx, spread), around(cy, spread));
			n++;
		end
		tx = around(cx, spread);
		ty = around(cy, spread);
		if (kind >= 20) begin
			send_sample(MODE_CAPTURE, tx, ty);
			n++;
		end
		repeat ($urandom_range(24, 4)) begin
			if ($urandom_range(1))
				send_sample(MODE_STEER, around(tx, 40), around(ty, 40));
			else
				send_sample(MODE_STEER, around(cx, spread), around(cy, spread));
			n++;
		end
	endtask

	// result side
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_steer(m_tdata);
			m_tready <= !rx_hold && (calm || $urandom_range(99) >= 21);
		end
	end

	// long receiver stall so the block backs up into its input
	initial begin
		rx_hold = 1'b0;
		wait (accepted >= 500);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int          done;
		int          n;
		logic [8:0]  tol;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_START;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		accepted = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// steer and capture on reset ranges
		send_sample(MODE_STEER, 0, 0);
		send_sample(MODE_STEER, -32768, 0);
		send_sample(MODE_CAPTURE, 0, 32767);
		send_sample(MODE_STEER, 0, -32768);
		// symmetric calibration gives exact axis headings
		send_sample(MODE_START, 0, 0);
		send_sample(MODE_CAL, 1000, 1000);
		send_sample(MODE_CAL, -1000, -1000);
		send_sample(MODE_STEER, 1000, 0);
		send_sample(MODE_STEER, 0, 1000);
		send_sample(MODE_STEER, 0, -1000);
		send_sample(MODE_STEER, -1000, 0);
		send_sample(MODE_CAPTURE, -1000, 3);
		send_sample(MODE_STEER, -1000, -3);
		send_sample(MODE_STEER, -1000, 5);
		send_sample(MODE_STEER, 0, 0);
		// widen to the full sample range
		send_sample(MODE_CAL, 32767, -32768);
		send_sample(MODE_CAL, -32768, 32767);
		send_sample(MODE_STEER, -32768, -32768);
		send_sample(MODE_STEER, 32767, 32767);
		send_sample(MODE_CAPTURE, 32767, -32768);
		send_sample(MODE_STEER, 32767, -32760);
		send_sample(MODE_START, -32768, 32767);
		send_sample(MODE_CAL, 12345, -23456);
		send_sample(MODE_STEER, 12345, -23456);
		drain_results();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: tol = 9'd0;
				1: tol = 9'd360;
				2: tol = 9'd511;
				3: tol = 9'd1;
				5: tol = 9'd180;
				7: tol = 9'd15;
				default: tol = 9'($urandom_range(511));
			endcase
			write_tolerance(tol);
			calm = (phase == 2);
			done = 0;
			while (done < 210) begin
				run_episode(n);
				done += n;
			end
			drain_results();
		end
		calm = 1'b0;

		repeat (50) @(posedge clk);
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/chs_pkg.sv
hw/rtl/chs_cordic.sv
hw/rtl/compass_heading_steer.sv
bench/compass_heading_steer_test.sv
